// File: rtl/histogram_bin_counter_unit_assert.svh
// Assertion macros used by the histogram bin counter RTL.
`ifndef HISTOGRAM_BIN_COUNTER_UNIT_ASSERT_SVH
`define HISTOGRAM_BIN_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define HBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define HBC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/hbc_pkg.sv
// Package with the types, sizes and helpers of the histogram bin counter.
`timescale 1ns / 1ps
package hbc_pkg;

	localparam int NUM_BIN_ENTRIES = 128;
	localparam int COUNT_BITS      = 32;
	localparam int BIN_IDX_W       = (NUM_BIN_ENTRIES > 1) ? $clog2(NUM_BIN_ENTRIES) : 1;
	localparam int SAMPLE_W        = 12;
	localparam int INDEX_W         = 7;
	localparam int OUT_COUNT_W     = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic {
		KIND_COUNT = 1'b0,
		KIND_READ  = 1'b1
	} hbc_kind_t;

	typedef struct packed {
		hbc_kind_t           kind;
		logic [SAMPLE_W-1:0] sample_value;
	} hbc_cmd_t;

	typedef struct packed {
		logic [INDEX_W-1:0]     bin_index;
		logic [OUT_COUNT_W-1:0] bin_count;
	} hbc_result_t;

	// Low bits of a count as reported on the result port.
	function automatic logic [OUT_COUNT_W-1:0] count_out(input logic [COUNT_BITS-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[OUT_COUNT_W-1:0];
	endfunction

endpackage

// File: rtl/histogram_bin_counter_unit.sv
// Histogram bin counter: a RAM of saturating bin counts updated by read-modify-write.
//
// Usage: a command is transferred at a rising edge with start high and busy low.
// A command of kind count adds one to the bin named by sample_value; samples at
// or above the number of bins are dropped. A command of kind read returns that
// bin's count (zero for a bin beyond the table) on result, with done high for
// exactly one cycle. Reads see every count transferred before them.
// Read path: a read's result goes through the registered RAM read, then through
// the update and output register.
// Throughput: one command per cycle, any mix of counts and reads; busy stays low.
// The count RAM's single write port, fed by the update stage, sets this rate; a
// write still in flight is forwarded to the next command's read.
// Reset: a flop per bin marks it written since reset; unmarked bins read as zero,
// so the table is clear at once with no clearing pass.
// The receiver cannot stall; done marks each result for one cycle only.
`timescale 1ns / 1ps
`include "histogram_bin_counter_unit_assert.svh"
module histogram_bin_counter_unit
	import hbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  hbc_cmd_t    cmd,
	output logic        done,
	output hbc_result_t result
);

	logic                   accept;
	logic [BIN_IDX_W-1:0]   rd_addr;
	logic [COUNT_BITS-1:0]  rd_data;

	logic                   v_s1;
	hbc_kind_t              kind_s1;
	logic [BIN_IDX_W-1:0]   addr_s1;
	logic [INDEX_W-1:0]     idx_s1;
	logic                   in_range_s1;

	logic                   fwd_v_q;
	logic [BIN_IDX_W-1:0]   fwd_addr_q;
	logic [COUNT_BITS-1:0]  fwd_data_q;

	logic [NUM_BIN_ENTRIES-1:0] valid_q;

	logic                   done_q;
	hbc_result_t            result_q;

	logic [COUNT_BITS-1:0]  base_count;
	logic [COUNT_BITS-1:0]  wr_data;
	logic                   wr_en;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign rd_addr = cmd.sample_value[BIN_IDX_W-1:0];

	hbc_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_BIN_ENTRIES)
	) u_count_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= cmd.kind;
			addr_s1     <= rd_addr;
			idx_s1      <= cmd.sample_value[INDEX_W-1:0];
			in_range_s1 <= (32'(cmd.sample_value) < 32'(NUM_BIN_ENTRIES));
		end
	end

	// The write of the previous cycle was not yet visible to the RAM read
	// issued in that same cycle, so it is forwarded here.
	always_comb begin
		if (fwd_v_q && (fwd_addr_q == addr_s1)) begin
			base_count = fwd_data_q;
		end else if (valid_q[addr_s1]) begin
			base_count = rd_data;
		end else begin
			base_count = '0;
		end
	end

	assign wr_en   = v_s1 && (kind_s1 == KIND_COUNT) && in_range_s1;
	assign wr_data = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			fwd_v_q <= wr_en;
			if (wr_en) begin
				valid_q[addr_s1] <= 1'b1;
			end
			done_q <= v_s1 && (kind_s1 == KIND_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= wr_data;
		end
		if (v_s1 && (kind_s1 == KIND_READ)) begin
			result_q.bin_index <= idx_s1;
			result_q.bin_count <= in_range_s1 ? count_out(base_count) : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`HBC_ASSERT_NXT(a_read_gives_done, v_s1 && (kind_s1 == KIND_READ), done, "read produced no result")
	`HBC_ASSERT_NXT(a_count_no_done, !(v_s1 && (kind_s1 == KIND_READ)), !done, "result without a read")
	`HBC_ASSERT_NXT(a_oor_read_zero, v_s1 && (kind_s1 == KIND_READ) && !in_range_s1, result.bin_count == '0, "out-of-range read returned nonzero count")
	`HBC_ASSERT_NXT(a_write_marks_valid, wr_en, valid_q[$past(addr_s1)], "written bin not marked valid")
	`HBC_ASSERT_IMP(a_write_nonzero, wr_en, wr_data != '0, "count wrapped to zero")

endmodule

// File: rtl/hbc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module hbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/histogram_bin_counter_unit_test.sv
// Self-checking testbench for the histogram bin counter: random count and read commands.
`timescale 1ns / 1ps
module histogram_bin_counter_unit_test;
	import hbc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1400;
	localparam int SHOWN_ERRORS = 10;

	typedef struct {
		hbc_cmd_t c;
		bit       hold_until_drained;
	} staged_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	hbc_cmd_t    cmd = '0;
	logic        busy;
	logic        done;
	hbc_result_t result;

	// Model of the table of bin counts.
	logic [COUNT_BITS-1:0] bin_tally [NUM_BIN_ENTRIES];

	staged_cmd_t staged_cmds[$];
	hbc_result_t awaited_results[$];

	logic cmd_taken = 1'b0;
	int   burst_left = 30;
	int   gap_left = 0;
	int   mismatches = 0;
	int   cycles = 0;

	histogram_bin_counter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic stage(input hbc_kind_t k, input int unsigned v, input bit hold);
		staged_cmd_t s;
		s.c.kind = k;
		s.c.sample_value = v[SAMPLE_W-1:0];
		s.hold_until_drained = hold;
		staged_cmds.push_back(s);
	endtask

	// Sender: holds a command until its transfer, then works in bursts with random gaps.
	always @(negedge clk) begin
		staged_cmd_t next_cmd;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !cmd_taken)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (staged_cmds.size() == 0) begin
				start <= 1'b0;
			end else if (staged_cmds[0].hold_until_drained && awaited_results.size() != 0) begin
				start <= 1'b0;
			end else begin
				next_cmd = staged_cmds.pop_front();
				cmd <= next_cmd.c;
				start <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Monitor: checks each result against the oldest expectation, then predicts new transfers.
	always @(posedge clk or negedge arst_n) begin
		hbc_result_t want;
		int unsigned sel;
		bit in_range;
		logic [63:0] wide;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= start && !busy;
			if (done) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("unexpected result: index %0d count %0d",
							result.bin_index, result.bin_count);
				end else begin
					want = awaited_results.pop_front();
					if (result.bin_index !== want.bin_index
							|| result.bin_count !== want.bin_count) begin
						mismatches++;
						if (mismatches <= SHOWN_ERRORS)
							$display("result mismatch: expected index %0d count %0d, got index %0d count %0d",
								want.bin_index, want.bin_count,
								result.bin_index, result.bin_count);
					end
				end
			end
			if (start && !busy) begin
				sel = cmd.sample_value;
				in_range = sel < NUM_BIN_ENTRIES;
				if (cmd.kind == KIND_COUNT) begin
					// Counts stop at their maximum; samples beyond the table are dropped.
					if (in_range && bin_tally[sel] != COUNT_MAX)
						bin_tally[sel] = bin_tally[sel] + 1'b1;
				end else begin
					wide = in_range ? 64'(bin_tally[sel]) : 64'd0;
					want.bin_index = sel[INDEX_W-1:0];
					want.bin_count = wide[OUT_COUNT_W-1:0];
					awaited_results.push_back(want);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned v;
		hbc_kind_t k;
		foreach (bin_tally[i])
			bin_tally[i] = '0;

		// Directed part: table edges, dropped samples, index truncation, and
		// counts followed at once by reads of the same bin.
		stage(KIND_READ, 0, 0);
		stage(KIND_COUNT, 0, 0);
		stage(KIND_READ, 0, 0);
		stage(KIND_COUNT, 0, 0);
		stage(KIND_COUNT, 0, 0);
		stage(KIND_READ, 0, 0);
		stage(KIND_COUNT, 127, 0);
		stage(KIND_COUNT, 127, 0);
		stage(KIND_READ, 127, 0);
		stage(KIND_COUNT, 128, 0);
		stage(KIND_READ, 128, 0);
		stage(KIND_COUNT, 4095, 0);
		stage(KIND_READ, 4095, 0);
		stage(KIND_READ, 127, 0);
		stage(KIND_COUNT, 1, 0);
		stage(KIND_READ, 1, 0);
		stage(KIND_READ, 2048, 0);
		stage(KIND_COUNT, 12'hAAA, 0);
		stage(KIND_COUNT, 12'h555, 0);
		stage(KIND_READ, 12'h055, 0);
		stage(KIND_READ, 12'h555, 0);
		stage(KIND_COUNT, 12'h055, 0);
		stage(KIND_READ, 12'h055, 0);
		stage(KIND_READ, 0, 0);

		// Random part: mostly a few hot bins so that updates collide in the pipeline.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: v = $urandom_range(0, 7);
				12, 13, 14, 15, 16: v = $urandom_range(0, NUM_BIN_ENTRIES - 1);
				default: v = $urandom_range(0, (1 << SAMPLE_W) - 1);
			endcase
			k = ($urandom_range(0, 4) < 3) ? KIND_COUNT : KIND_READ;
			if ($urandom_range(0, 9) == 0) begin
				stage(KIND_COUNT, v, i == 500 || i == 1100);
				stage(KIND_READ, v, 0);
			end else begin
				stage(k, v, i == 500 || i == 1100);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (staged_cmds.size() != 0 || start)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/hbc_pkg.sv
rtl/hbc_ram.sv
rtl/histogram_bin_counter_unit.sv
tb/histogram_bin_counter_unit_test.sv
